[hw/rtl/udp_to_tcp_header_rewriter_unit_assert.svh]
// Assertion macros for the UDP to TCP header rewriter.
`ifndef UDP_TO_TCP_HEADER_REWRITER_UNIT_ASSERT_SVH
`define UDP_TO_TCP_HEADER_REWRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UDPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udpt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udpt: next-cycle check failed");

`endif

[hw/rtl/udpt_pkg.sv]
// Types and constants shared by the UDP to TCP header rewriter.
`timescale 1ns / 1ps

package udpt_pkg;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        last_word;
        logic        odd_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_word;
        logic        out_last;
        logic        out_odd_end;
        logic        funneled;
    } out_item_t;

    // Header fields captured while the headers are collected.
    typedef struct packed {
        logic [15:0] old_len;
        logic [15:0] old_tp;
        logic [15:0] old_ck;
        logic [15:0] udp_len;
    } hdr_t;

    // Rewritten header fields.
    typedef struct packed {
        logic [15:0] new_len;
        logic [15:0] new_tp;
        logic [15:0] ip_ck;
        logic [15:0] tcp_ck;
    } csum_t;

    localparam logic [1:0] CFG_MATCH_PORT = 2'd0;
    localparam logic [1:0] CFG_TCP_SRC    = 2'd1;
    localparam logic [1:0] CFG_TCP_DST    = 2'd2;

    localparam int ETH_WORDS = 7;
    localparam int TCP_WORDS = 10;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] LEN_GROWTH     = 16'd20;

    localparam logic [15:0] TCP_SEQ_HI = 16'hCAFE;
    localparam logic [15:0] TCP_SEQ_LO = 16'hBABE;
    localparam logic [15:0] TCP_ACK_HI = 16'hBABE;
    localparam logic [15:0] TCP_ACK_LO = 16'hCAFE;
    localparam logic [15:0] TCP_FLAGS  = 16'h5002;
    localparam logic [15:0] TCP_WINDOW = 16'd1024;

    // Fixed part of the TCP checksum sum: constant header words, the two
    // pairs of a word and its complement that cancel to all ones, and the
    // protocol change in the pseudo-header.
    localparam logic [20:0] TCP_CONST_SUM =
        21'(TCP_SEQ_HI) + 21'(TCP_SEQ_LO) + 21'(TCP_ACK_HI) + 21'(TCP_ACK_LO)
        + 21'(TCP_FLAGS) + 21'(TCP_WINDOW) + 21'(16'hFFFF) + 21'(16'hFFFF)
        + 21'({8'hFF, ~PROTO_UDP}) + 21'({8'h00, PROTO_TCP});

endpackage

[hw/rtl/udp_to_tcp_header_rewriter_unit.sv]
// Top level of the UDP to TCP header rewriter.
`timescale 1ns / 1ps

// The block takes an Ethernet frame as 16-bit words and holds the Ethernet,
// IPv4 and UDP headers in a header memory of HEADER_WORDS entries until it
// can decide. An IPv4 UDP frame whose destination port equals the
// configured match port leaves with a 20-byte TCP header (SYN, fixed seq and
// ack, window 1024) after the IP header, protocol set to TCP, total length
// grown by 20 and both checksums updated; every other frame leaves as it
// came. While headers are collected a word is taken in every cycle and
// nothing leaves. Once the verdict is known the held words, and the TCP
// words where funneled, are sent one by one, each read from the header
// memory and then loaded into the output register; input is stalled
// during that burst of at most 51 transfers. The rest of the frame then
// passes at one word per cycle while the output is not stalled. The memory
// needs no clearing pass: only entries written for the current frame are
// ever read. Configuration may be written at any time the block is idle.

module udp_to_tcp_header_rewriter_unit
#(
    parameter int HEADER_WORDS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  udpt_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output udpt_pkg::out_item_t   out_data
);

    `include "udp_to_tcp_header_rewriter_unit_assert.svh"

    // The counter holds the word count of a frame plus the inserted words.
    localparam int CW = $clog2(HEADER_WORDS + udpt_pkg::TCP_WORDS + 1);
    localparam int AW = $clog2(HEADER_WORDS);

    localparam logic [CW-1:0] N_ETYPE  = CW'(udpt_pkg::ETH_WORDS);
    localparam logic [CW-1:0] N_IHL    = CW'(udpt_pkg::ETH_WORDS + 1);
    localparam logic [CW-1:0] N_PROTO  = CW'(udpt_pkg::ETH_WORDS + 5);
    localparam logic [CW-1:0] P_LEN    = CW'(udpt_pkg::ETH_WORDS + 1);
    localparam logic [CW-1:0] P_TP     = CW'(udpt_pkg::ETH_WORDS + 4);
    localparam logic [CW-1:0] P_CK     = CW'(udpt_pkg::ETH_WORDS + 5);
    localparam logic [CW-1:0] N_LIMIT  = CW'(HEADER_WORDS);
    localparam logic [CW-1:0] N_TCP    = CW'(udpt_pkg::TCP_WORDS);

    typedef enum logic [3:0]
    {
        ST_COLLECT = 4'b0001,
        ST_ISSUE   = 4'b0010,
        ST_LOAD    = 4'b0100,
        ST_PASS    = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] total_reg, total_next;
    logic [4:0]  ihw_reg, ihw_next;
    logic        fun_reg, fun_next;
    logic        flast_reg, flast_next;
    logic        fodd_reg, fodd_next;
    logic [15:0] match_port_reg;
    logic [15:0] tcp_src_reg;
    logic [15:0] tcp_dst_reg;
    logic [15:0] udp_dst_reg;
    udpt_pkg::hdr_t  hdr_reg;
    udpt_pkg::csum_t csum;

    logic [15:0] hdr_mem [HEADER_WORDS];
    logic [15:0] rd_data_reg;
    logic [CW-1:0] rd_addr;

    logic        out_valid_reg, out_valid_next;
    udpt_pkg::out_item_t out_data_reg, out_data_next;

    logic        in_accept;
    logic        out_free;
    logic [CW-1:0] n;
    logic [CW-1:0] ub;
    logic        verdict_pass;
    logic        verdict_fun;
    logic        in_tcp;
    logic [CW-1:0] tcp_j;
    logic [15:0] flush_word;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign n         = idx_reg + CW'(1);
    assign ub        = N_ETYPE + CW'(ihw_reg);

    always_comb
    begin
        case (state_reg)
            ST_COLLECT: in_stall = 1'b0;
            ST_PASS:    in_stall = !out_free;
            default:    in_stall = 1'b1;
        endcase
    end

    // Verdict on the word being collected.
    always_comb
    begin
        verdict_pass = 1'b0;
        verdict_fun  = 1'b0;
        ihw_next     = ihw_reg;
        if (n == N_ETYPE)
        begin
            verdict_pass = (in_data.frame_word != udpt_pkg::ETHERTYPE_IPV4);
        end
        else if (n == N_IHL)
        begin
            if (in_data.frame_word[11:8] < 4'd5)
            begin
                verdict_pass = 1'b1;
            end
            else
            begin
                ihw_next = {in_data.frame_word[11:8], 1'b0};
            end
        end
        else if (n == N_PROTO)
        begin
            verdict_pass = (in_data.frame_word[7:0] != udpt_pkg::PROTO_UDP);
        end
        else if (n > N_PROTO && n == ub + CW'(4))
        begin
            if (in_data.last_word && in_data.odd_end)
            begin
                verdict_pass = 1'b1;
            end
            else if (udp_dst_reg == match_port_reg)
            begin
                verdict_fun = 1'b1;
            end
            else
            begin
                verdict_pass = 1'b1;
            end
        end
        if (!verdict_pass && !verdict_fun && (in_data.last_word || n >= N_LIMIT))
        begin
            verdict_pass = 1'b1;
        end
    end

    // Word of the flush burst at output position k_reg.
    assign in_tcp = fun_reg && k_reg >= ub && k_reg < ub + N_TCP;
    assign tcp_j  = k_reg - ub;

    always_comb
    begin
        if (in_tcp)
        begin
            rd_addr = '0;
        end
        else if (fun_reg && k_reg >= ub + N_TCP)
        begin
            rd_addr = k_reg - N_TCP;
        end
        else
        begin
            rd_addr = k_reg;
        end
    end

    always_comb
    begin
        flush_word = rd_data_reg;
        if (in_tcp)
        begin
            case (tcp_j[3:0])
                4'd0:    flush_word = tcp_src_reg;
                4'd1:    flush_word = tcp_dst_reg;
                4'd2:    flush_word = udpt_pkg::TCP_SEQ_HI;
                4'd3:    flush_word = udpt_pkg::TCP_SEQ_LO;
                4'd4:    flush_word = udpt_pkg::TCP_ACK_HI;
                4'd5:    flush_word = udpt_pkg::TCP_ACK_LO;
                4'd6:    flush_word = udpt_pkg::TCP_FLAGS;
                4'd7:    flush_word = udpt_pkg::TCP_WINDOW;
                4'd8:    flush_word = csum.tcp_ck;
                default: flush_word = 16'h0000;
            endcase
        end
        else if (fun_reg && k_reg == P_LEN)
        begin
            flush_word = csum.new_len;
        end
        else if (fun_reg && k_reg == P_TP)
        begin
            flush_word = csum.new_tp;
        end
        else if (fun_reg && k_reg == P_CK)
        begin
            flush_word = csum.ip_ck;
        end
    end

    // Sequencer: collect, then issue a read and load the output register for
    // each flushed word, then pass the rest of the frame unless it has ended.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        fun_next       = fun_reg;
        flast_next     = flast_reg;
        fodd_next      = fodd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_accept)
                begin
                    if (verdict_pass || verdict_fun)
                    begin
                        idx_next   = '0;
                        k_next     = '0;
                        total_next = verdict_fun ? n + N_TCP : n;
                        fun_next   = verdict_fun;
                        flast_next = in_data.last_word;
                        fodd_next  = in_data.odd_end;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        idx_next = n;
                    end
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.out_word     = flush_word;
                    out_data_next.out_last     = flast_reg && (k_reg == total_reg - CW'(1));
                    out_data_next.out_odd_end  = !fun_reg && flast_reg && fodd_reg
                                                 && (k_reg == total_reg - CW'(1));
                    out_data_next.funneled     = fun_reg;
                    k_next                     = k_reg + CW'(1);
                    if (k_reg == total_reg - CW'(1))
                    begin
                        state_next = flast_reg ? ST_COLLECT : ST_PASS;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_PASS:
            begin
                if (in_accept)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.out_word    = in_data.frame_word;
                    out_data_next.out_last    = in_data.last_word;
                    out_data_next.out_odd_end = in_data.last_word && in_data.odd_end;
                    out_data_next.funneled    = fun_reg;
                    if (in_data.last_word)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            idx_reg        <= '0;
            k_reg          <= '0;
            total_reg      <= '0;
            ihw_reg        <= '0;
            fun_reg        <= 1'b0;
            flast_reg      <= 1'b0;
            fodd_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            match_port_reg <= '0;
            tcp_src_reg    <= '0;
            tcp_dst_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            fun_reg       <= fun_next;
            flast_reg     <= flast_next;
            fodd_reg      <= fodd_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_COLLECT && in_accept)
            begin
                ihw_reg <= ihw_next;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    udpt_pkg::CFG_MATCH_PORT: match_port_reg <= cfg_wdata;
                    udpt_pkg::CFG_TCP_SRC:    tcp_src_reg    <= cfg_wdata;
                    udpt_pkg::CFG_TCP_DST:    tcp_dst_reg    <= cfg_wdata;
                    default:                  ;
                endcase
            end
        end
    end

    // Payload registers and captured header fields.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (state_reg == ST_COLLECT && in_accept)
        begin
            if (idx_reg == P_LEN)
            begin
                hdr_reg.old_len <= in_data.frame_word;
            end
            if (idx_reg == P_TP)
            begin
                hdr_reg.old_tp <= in_data.frame_word;
            end
            if (idx_reg == P_CK)
            begin
                hdr_reg.old_ck <= in_data.frame_word;
            end
            if (idx_reg == ub + CW'(1))
            begin
                udp_dst_reg <= in_data.frame_word;
            end
            if (idx_reg == ub + CW'(2))
            begin
                hdr_reg.udp_len <= in_data.frame_word;
            end
        end
    end

    // Header memory: written while collecting, read once per flushed word.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COLLECT && in_accept)
        begin
            hdr_mem[idx_reg[AW-1:0]] <= in_data.frame_word;
        end
        if (state_reg == ST_ISSUE)
        begin
            rd_data_reg <= hdr_mem[rd_addr[AW-1:0]];
        end
    end

    udpt_csum u_csum
    (
        .clk     (clk),
        .hdr     (hdr_reg),
        .tcp_src (tcp_src_reg),
        .tcp_dst (tcp_dst_reg),
        .csum    (csum)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A flushed word waiting on a stalled output keeps the sequencer in place.
    `UDPT_ASSERT_NEXT(a_load_holds, state_reg == ST_LOAD && out_valid_reg && out_stall, state_reg == ST_LOAD && k_reg == $past(k_reg))
    // Every memory read is followed by the load of its word.
    `UDPT_ASSERT_NEXT(a_issue_then_load, state_reg == ST_ISSUE, state_reg == ST_LOAD)
    // The collect counter never runs past the header memory.
    `UDPT_ASSERT_NOW(a_idx_in_range, state_reg == ST_COLLECT, idx_reg < N_LIMIT)

endmodule

[hw/rtl/udpt_csum.sv]
// Pipelined checksum and length rewrite for funneled frames.
`timescale 1ns / 1ps

module udpt_csum
(
    input  logic               clk,
    input  udpt_pkg::hdr_t     hdr,
    input  logic [15:0]        tcp_src,
    input  logic [15:0]        tcp_dst,
    output udpt_pkg::csum_t    csum
);

    logic [15:0] new_len;
    logic [15:0] new_tp;
    logic [17:0] ip_a_reg;
    logic [15:0] tp_diff_a_reg;
    logic [15:0] tp_diff_b_reg;
    logic [18:0] ip_s_reg;
    logic [20:0] tcp_a_reg;
    logic [16:0] len_diff_reg;
    logic [20:0] tcp_s_reg;
    logic [16:0] ip_f1;
    logic [15:0] ip_f2;
    logic [16:0] tcp_f1;
    logic [15:0] tcp_f2;

    assign new_len = hdr.old_len + udpt_pkg::LEN_GROWTH;
    assign new_tp  = {hdr.old_tp[15:8], udpt_pkg::PROTO_TCP};

    // The complements are taken at 16 bits before they are widened.
    always_ff @(posedge clk)
    begin
        ip_a_reg      <= {2'b00, ~hdr.old_ck} + {2'b00, ~hdr.old_len} + {2'b00, new_len};
        tp_diff_a_reg <= ~hdr.old_tp;
        tp_diff_b_reg <= new_tp;
        ip_s_reg      <= 19'(ip_a_reg) + 19'(tp_diff_a_reg) + 19'(tp_diff_b_reg);
        tcp_a_reg     <= udpt_pkg::TCP_CONST_SUM + 21'(tcp_src) + 21'(tcp_dst);
        len_diff_reg  <= {1'b0, ~hdr.udp_len}
                         + 17'(16'(hdr.udp_len + udpt_pkg::LEN_GROWTH));
        tcp_s_reg     <= tcp_a_reg + 21'(len_diff_reg);
    end

    // End-around carry folds; both sums are never zero.
    assign ip_f1  = 17'(ip_s_reg[15:0]) + 17'(ip_s_reg[18:16]);
    assign ip_f2  = ip_f1[15:0] + 16'(ip_f1[16]);
    assign tcp_f1 = 17'(tcp_s_reg[15:0]) + 17'(tcp_s_reg[20:16]);
    assign tcp_f2 = tcp_f1[15:0] + 16'(tcp_f1[16]);

    always_ff @(posedge clk)
    begin
        csum.new_len <= new_len;
        csum.new_tp  <= new_tp;
        csum.ip_ck   <= ~ip_f2;
        csum.tcp_ck  <= ~tcp_f2;
    end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the UDP to TCP header rewriter unit.
`timescale 1ns / 1ps

// Frames are built word by word and sent through the input channel. Each
// accepted transfer is fed to a behavioural copy of the rewriter held in
// this module. That copy keeps its own header memory, frame phase and
// register values, and it queues the output words the block should produce.
// A monitor process takes every accepted output transfer and compares it,
// field by field, with the oldest queued word. Both channels idle at random,
// and the receiver can be told to hold off for a long stretch so that the
// block fills up and stalls its input.
module testbench;

    localparam int HDR_DEPTH     = 64;
    localparam int DRAIN_CYCLES  = 120;     // extra wait once no output words are expected
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 120;

    // Frame phases of the behavioural copy.
    typedef enum logic [1:0] {PH_COLLECT, PH_PASS, PH_PASS_FUN} frame_phase_t;

    // Kinds of frame that the generator can build.
    typedef enum logic [2:0]
    {
        FR_FUNNEL, FR_NOT_IP, FR_SHORT_IHL, FR_NOT_UDP, FR_PORT_MISS, FR_TRUNCATED
    } frame_kind_t;

    // Fill of the free-running frame fields: random, all zeros or all ones.
    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_addr = udpt_pkg::CFG_MATCH_PORT;
    logic [15:0]         cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    udpt_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    udpt_pkg::out_item_t out_data;

    udp_to_tcp_header_rewriter_unit #(.HEADER_WORDS(HDR_DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // State of the behavioural copy of the rewriter.
    logic [15:0]  hdr_mem [HDR_DEPTH];
    logic [6:0]   hdr_count = '0;
    frame_phase_t phase = PH_COLLECT;
    int unsigned  ip_words = 0;
    logic [15:0]  match_port = '0;
    logic [15:0]  tcp_src = '0;
    logic [15:0]  tcp_dst = '0;

    udpt_pkg::out_item_t expected_words [$];

    int           mismatches = 0;
    int           words_sent = 0;
    int           cycle_count = 0;

    // Idling controls, changed by the test tasks.
    int           send_gap_max = 15;
    int           recv_gap_max = 15;
    int           long_hold = 0;
    fill_t        fill = FILL_RANDOM;

    // ------------------------------------------------------------------
    // Behavioural copy
    // ------------------------------------------------------------------

    // 16-bit ones' complement addition with end-around carry.
    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic void queue_word(logic [15:0] w, logic last, logic odd, logic fun);
        udpt_pkg::out_item_t o;
        o.out_word    = w;
        o.out_last    = last;
        o.out_odd_end = last ? odd : 1'b0;
        o.funneled    = fun;
        expected_words.push_back(o);
    endfunction

    // Release the held words as they came.
    function automatic void release_unchanged(int n, logic last, logic odd);
        for (int i = 0; i < n; i++)
        begin
            queue_word(hdr_mem[6'(i)], (i + 1 == n) ? last : 1'b0, odd, 1'b0);
        end
        phase = last ? PH_COLLECT : PH_PASS;
        hdr_count = '0;
    endfunction

    // Release the held words with the IP fields rewritten and the TCP header
    // placed after the IP header.
    function automatic void release_with_tcp(int n, logic last);
        int          ub;
        logic [15:0] old_len, old_tp, new_len, new_tp, ulen, uck, ip_ck, addr_sum, d;
        logic [15:0] tcp [udpt_pkg::TCP_WORDS];
        logic [15:0] w;
        ub       = udpt_pkg::ETH_WORDS + int'(ip_words);
        old_len  = hdr_mem[6'(udpt_pkg::ETH_WORDS + 1)];
        old_tp   = hdr_mem[6'(udpt_pkg::ETH_WORDS + 4)];
        new_len  = old_len + udpt_pkg::LEN_GROWTH;
        new_tp   = {old_tp[15:8], udpt_pkg::PROTO_TCP};
        ulen     = hdr_mem[6'(ub + 2)];
        uck      = hdr_mem[6'(ub + 3)];

        ip_ck = ~hdr_mem[6'(udpt_pkg::ETH_WORDS + 5)];
        ip_ck = ones_add(ip_ck, ~old_len);
        ip_ck = ones_add(ip_ck, new_len);
        ip_ck = ones_add(ip_ck, ~old_tp);
        ip_ck = ones_add(ip_ck, new_tp);

        addr_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            addr_sum = ones_add(addr_sum, hdr_mem[6'(udpt_pkg::ETH_WORDS + 6 + i)]);
        end

        tcp[0] = tcp_src;
        tcp[1] = tcp_dst;
        tcp[2] = udpt_pkg::TCP_SEQ_HI;
        tcp[3] = udpt_pkg::TCP_SEQ_LO;
        tcp[4] = udpt_pkg::TCP_ACK_HI;
        tcp[5] = udpt_pkg::TCP_ACK_LO;
        tcp[6] = udpt_pkg::TCP_FLAGS;
        tcp[7] = udpt_pkg::TCP_WINDOW;
        tcp[8] = '0;
        tcp[9] = '0;

        // Start from the UDP sum, add the new header, the unchanged address
        // pair, the protocol and length changes, then the old checksum word
        // which now sits in the payload.
        d = ~uck;
        for (int i = 0; i < udpt_pkg::TCP_WORDS; i++)
        begin
            d = ones_add(d, tcp[4'(i)]);
        end
        d = ones_add(d, ~addr_sum);
        d = ones_add(d, addr_sum);
        d = ones_add(d, ~{8'h00, udpt_pkg::PROTO_UDP});
        d = ones_add(d, {8'h00, udpt_pkg::PROTO_TCP});
        d = ones_add(d, ~ulen);
        d = ones_add(d, ulen + udpt_pkg::LEN_GROWTH);
        d = ones_add(d, 16'h0000);
        d = ones_add(d, uck);
        tcp[8] = ~d;

        for (int i = 0; i < ub; i++)
        begin
            w = hdr_mem[6'(i)];
            if (i == udpt_pkg::ETH_WORDS + 1)
                w = new_len;
            else if (i == udpt_pkg::ETH_WORDS + 4)
                w = new_tp;
            else if (i == udpt_pkg::ETH_WORDS + 5)
                w = ~ip_ck;
            queue_word(w, 1'b0, 1'b0, 1'b1);
        end
        for (int i = 0; i < udpt_pkg::TCP_WORDS; i++)
        begin
            queue_word(tcp[4'(i)], 1'b0, 1'b0, 1'b1);
        end
        for (int i = ub; i < n; i++)
        begin
            queue_word(hdr_mem[6'(i)], (i + 1 == n) ? last : 1'b0, 1'b0, 1'b1);
        end

        phase = last ? PH_COLLECT : PH_PASS_FUN;
        hdr_count = '0;
    endfunction

    // Advance the copy by one accepted input transfer.
    function automatic void predict_rewrite(udpt_pkg::in_item_t it);
        int unsigned n;
        logic [3:0]  ihl;
        bit          pass_now, funnel_now;
        pass_now   = 1'b0;
        funnel_now = 1'b0;

        if (phase != PH_COLLECT)
        begin
            queue_word(it.frame_word, it.last_word, it.odd_end, phase == PH_PASS_FUN);
            if (it.last_word)
                phase = PH_COLLECT;
            return;
        end

        if (hdr_count < HDR_DEPTH)
            hdr_mem[hdr_count[5:0]] = it.frame_word;
        hdr_count = hdr_count + 7'd1;
        n = 32'(hdr_count);

        if (n == udpt_pkg::ETH_WORDS)
        begin
            pass_now = (it.frame_word != udpt_pkg::ETHERTYPE_IPV4);
        end
        else if (n == udpt_pkg::ETH_WORDS + 1)
        begin
            ihl = it.frame_word[11:8];
            if (ihl < 4'd5)
                pass_now = 1'b1;
            else
                ip_words = 32'(ihl) * 2;
        end
        else if (n == udpt_pkg::ETH_WORDS + 5)
        begin
            pass_now = (it.frame_word[7:0] != udpt_pkg::PROTO_UDP);
        end
        else if (n > udpt_pkg::ETH_WORDS + 5 && n == udpt_pkg::ETH_WORDS + ip_words + 4)
        begin
            // The UDP header is complete; an odd final word means it is not.
            if (it.last_word && it.odd_end)
                pass_now = 1'b1;
            else if (hdr_mem[6'(udpt_pkg::ETH_WORDS + ip_words + 1)] == match_port)
                funnel_now = 1'b1;
            else
                pass_now = 1'b1;
        end

        if (!pass_now && !funnel_now && (it.last_word || n >= HDR_DEPTH))
            pass_now = 1'b1;

        if (pass_now)
            release_unchanged(int'(n), it.last_word, it.odd_end);
        else if (funnel_now)
            release_with_tcp(int'(n), it.last_word);
    endfunction

    // ------------------------------------------------------------------
    // Channels
    // ------------------------------------------------------------------

    // Output side: after each accepted transfer the receiver draws how many
    // cycles it stalls. A long hold, when requested, overrides the draw.
    int recv_wait = 0;
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end
        else if (recv_wait > 0)
        begin
            out_stall <= 1'b1;
            recv_wait <= recv_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                recv_wait <= $urandom_range(0, recv_gap_max);
        end
    end

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
        end
    endfunction

    // Every accepted output transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        udpt_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transfer: got %h", out_data);
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("out_word", want.out_word, out_data.out_word);
                check_field("out_last", 16'(want.out_last), 16'(out_data.out_last));
                check_field("out_odd_end", 16'(want.out_odd_end),
                            16'(out_data.out_odd_end));
                check_field("funneled", 16'(want.funneled), 16'(out_data.funneled));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one input word and wait until the transfer is taken. Valid is
    // only lowered when a gap is drawn, so it never drops and rises in one
    // step.
    task automatic send_word(udpt_pkg::in_item_t it);
        int gap;
        gap = int'($urandom_range(0, send_gap_max));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        predict_rewrite(it);
        words_sent++;
    endtask

    // Stop offering and wait until every expected word has been seen, plus
    // the time a frame still held inside the block could take.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; the block must be idle.
    task automatic set_ports(logic [15:0] m, logic [15:0] s, logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= udpt_pkg::CFG_MATCH_PORT;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_addr  <= udpt_pkg::CFG_TCP_SRC;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_addr  <= udpt_pkg::CFG_TCP_DST;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        match_port = m;
        tcp_src    = s;
        tcp_dst    = d;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------

    function automatic logic [15:0] free_word();
        case (fill)
            FILL_ZEROS: return 16'h0000;
            FILL_ONES:  return 16'hFFFF;
            default:    return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Build a frame of the given kind and send it. ihl_req of zero draws
    // the header length at random.
    task automatic send_frame(frame_kind_t kind, int payload, logic zero_ck, int ihl_req);
        logic [15:0]        fw [$];
        udpt_pkg::in_item_t it;
        int                 ihl, opts, hdr_len, cut;
        logic [15:0]        ethertype, dport, fr;
        logic [7:0]         proto;

        if (kind == FR_SHORT_IHL)
            ihl = int'($urandom_range(0, 4));
        else
            ihl = (ihl_req != 0) ? ihl_req : int'($urandom_range(5, 15));
        opts = (ihl >= 5) ? ihl * 2 - 10 : 0;

        ethertype = (kind == FR_NOT_IP)
                    ? (udpt_pkg::ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 65535)))
                    : udpt_pkg::ETHERTYPE_IPV4;
        proto     = (kind == FR_NOT_UDP)
                    ? (udpt_pkg::PROTO_UDP ^ 8'($urandom_range(1, 255)))
                    : udpt_pkg::PROTO_UDP;
        dport     = (kind == FR_PORT_MISS) ? (match_port ^ 16'($urandom_range(1, 65535)))
                                           : match_port;

        for (int i = 0; i < 6; i++)
            fw.push_back(free_word());
        fw.push_back(ethertype);
        fr = free_word();
        fw.push_back({4'h4, 4'(ihl), fr[7:0]});
        for (int i = 0; i < 3; i++)
            fw.push_back(free_word());
        fr = free_word();
        fw.push_back({fr[15:8], proto});
        for (int i = 0; i < 5 + opts; i++)
            fw.push_back(free_word());
        fw.push_back(free_word());              // UDP source port
        fw.push_back(dport);
        fw.push_back(free_word());              // UDP length
        fw.push_back(zero_ck ? 16'h0000 : free_word());
        for (int i = 0; i < payload; i++)
            fw.push_back(free_word());

        // A truncated frame ends somewhere inside its headers.
        if (kind == FR_TRUNCATED)
        begin
            hdr_len = udpt_pkg::ETH_WORDS + ihl * 2 + 4;
            cut = int'($urandom_range(1, hdr_len - 1));
            while (fw.size() > cut) void'(fw.pop_back());
        end

        foreach (fw[i])
        begin
            it.frame_word = fw[i];
            it.last_word  = (i == fw.size() - 1);
            // Odd marks on inner words must be ignored by the block.
            it.odd_end    = it.last_word ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 3) == 0);
            send_word(it);
        end
    endtask

    function automatic frame_kind_t draw_kind();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) return FR_FUNNEL;
        if (r < 68) return FR_NOT_IP;
        if (r < 74) return FR_SHORT_IHL;
        if (r < 80) return FR_NOT_UDP;
        if (r < 88) return FR_PORT_MISS;
        return FR_TRUNCATED;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register extremes with field extremes: all-zero and all-ones frames.
    task automatic test_register_extremes();
        set_ports(16'h0000, 16'h0000, 16'h0000);
        fill = FILL_ZEROS;
        send_frame(FR_FUNNEL, 0, 1'b1, 5);
        wait_drained();
        set_ports(16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill = FILL_ONES;
        send_frame(FR_FUNNEL, 1, 1'b0, 15);
        wait_drained();
        fill = FILL_RANDOM;
    endtask

    // Frames left unchanged by ethertype, IHL, protocol, port or truncation,
    // and a funneled frame with a zero UDP checksum.
    task automatic test_special_frames();
        set_ports(16'h1234, 16'h8001, 16'h7FFE);
        send_frame(FR_NOT_IP, 0, 1'b0, 0);
        send_frame(FR_SHORT_IHL, 0, 1'b0, 0);
        send_frame(FR_NOT_UDP, 0, 1'b0, 5);
        send_frame(FR_PORT_MISS, 1, 1'b0, 5);
        send_frame(FR_TRUNCATED, 0, 1'b0, 6);
        send_frame(FR_FUNNEL, 2, 1'b1, 5);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the block fills.
    task automatic test_long_hold();
        long_hold = 500;
        send_gap_max = 0;
        repeat (3) send_frame(FR_FUNNEL, int'($urandom_range(0, 4)), 1'b0, 0);
        send_gap_max = 15;
        wait_drained();
    endtask

    // Random frames under several register settings and idling patterns.
    task automatic test_random_traffic();
        int goal;
        goal = words_sent + RANDOM_ITEMS;
        for (int p = 0; p < 4; p++)
        begin
            set_ports(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
            // One phase with no idling on either side.
            send_gap_max = (p == 2) ? 0 : 15;
            recv_gap_max = (p == 2) ? 0 : 15;
            while (words_sent < goal - (3 - p) * RANDOM_ITEMS / 4)
            begin
                send_frame(draw_kind(), int'($urandom_range(0, 6)),
                           $urandom_range(0, 4) == 0, 0);
                // Now and then the sender pauses until everything is out.
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end
        send_gap_max = 15;
        recv_gap_max = 15;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_extremes();
        test_special_frames();
        test_long_hold();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
